// ===== rtl/core/nfaa_pkg.sv =====
// Shared constants and codes for the next free address allocator.
`default_nettype none
package nfaa_pkg;
  localparam int unsigned AddrBitsDef = 10;
  localparam int unsigned AddrW       = 10;
  localparam int unsigned CountW      = 11;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CfgW        = 4;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;

  localparam logic [CfgW-1:0] AddrBitsReset = 4'd10;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic [StatusW-1:0] StatusDone      = 2'd0;
  localparam logic [StatusW-1:0] StatusExhausted = 2'd1;
  localparam logic [StatusW-1:0] StatusNotAlloc  = 2'd2;

  localparam logic RegAddrBits = 1'b0;
endpackage
`default_nettype wire

// ===== rtl/core/next_free_address_allocator_top.sv =====
// Top level of the next free address allocator: tree walker, node memory and register port.
//
// channel  | handshake                | beat payload
// ---------+--------------------------+-------------------------------------------
// request  | start_i while !busy_o    | kind_i, address_i
// result   | result_valid_o, 1 cycle  | granted_address_o, status_o, pool_empty_o,
//          |                          | allocated_count_o
// config   | APB write, pready high   | pwdata[3:0] = address_bits
//
// A request walks the tree through a single-port node memory with a registered read;
// busy_o stays high until the result beat, so a new request waits until the walk is done.
// After reset and after every address_bits write a clearing pass wipes all 2^(ADDR_BITS+1)
// node memory entries while busy_o stays high.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none
module next_free_address_allocator_top #(
  parameter int unsigned ADDR_BITS = nfaa_pkg::AddrBitsDef
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  output logic                                  busy_o,
  input  wire                                   kind_i,
  input  wire  [nfaa_pkg::AddrW-1:0]            address_i,
  output logic                                  result_valid_o,
  output logic [nfaa_pkg::AddrW-1:0]            granted_address_o,
  output logic [nfaa_pkg::StatusW-1:0]          status_o,
  output logic                                  pool_empty_o,
  output logic [nfaa_pkg::CountW-1:0]           allocated_count_o,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [nfaa_pkg::PaddrW-1:0]           paddr,
  input  wire  [nfaa_pkg::PdataW-1:0]           pwdata,
  output logic [nfaa_pkg::PdataW-1:0]           prdata,
  output logic                                  pready
);
  localparam int unsigned NodeW  = ADDR_BITS + 1;
  localparam int unsigned Depth  = 2 ** NodeW;
  localparam int unsigned AW     = nfaa_pkg::AddrW;
  localparam int unsigned CW     = nfaa_pkg::CountW;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StClear  = 9'b000000010,
    StLeaf   = 9'b000000100,
    StClimb  = 9'b000001000,
    StSib    = 9'b000010000,
    StDesc   = 9'b000100000,
    StDchk   = 9'b001000000,
    StFix    = 9'b010000000,
    StFixChk = 9'b100000000
  } state_e;

  state_e                     state_q, state_d;
  logic [nfaa_pkg::CfgW-1:0]  cfg_q, cfg_d;
  logic [NodeW-1:0]           node_q, node_d;
  logic [NodeW-1:0]           leaf_q, leaf_d;
  logic [NodeW-1:0]           clr_q, clr_d;
  logic [NodeW-1:0]           used_q, used_d;
  logic                       val_q, val_d;
  logic                       kind_q, kind_d;
  logic                       rv_q, rv_d;
  logic [AW-1:0]              gnt_q, gnt_d;
  logic [nfaa_pkg::StatusW-1:0] st_q, st_d;

  logic                       mem [Depth];
  logic                       rd_q;
  logic [NodeW-1:0]           mem_ra;
  logic [NodeW-1:0]           mem_wa;
  logic                       mem_we;
  logic                       mem_wd;

  logic [3:0]                 h_eff;
  logic [NodeW-1:0]           size_w;
  logic [NodeW-1:0]           mask_w;
  logic [NodeW+AW-1:0]        addr_wide;
  logic [NodeW-1:0]           addr_in;
  logic [NodeW+AW-1:0]        gnt_wide;
  logic [NodeW+CW-1:0]        cnt_wide;
  logic                       cfg_wr;
  logic                       accept;
  logic                       is_leaf;

  // Effective width: zero counts as one, anything above the built depth is clamped.
  always_comb begin
    h_eff = cfg_q;
    if (cfg_q == '0) begin
      h_eff = 4'd1;
    end else if ({1'b0, cfg_q} > 5'(ADDR_BITS)) begin
      h_eff = 4'(ADDR_BITS);
    end
  end

  assign size_w    = NodeW'(1) << h_eff;
  assign mask_w    = size_w - NodeW'(1);
  assign addr_wide = {{NodeW{1'b0}}, address_i};
  assign addr_in   = addr_wide[NodeW-1:0] & mask_w;
  assign is_leaf   = (node_q & size_w) != '0;
  assign gnt_wide  = {{AW{1'b0}}, leaf_q & mask_w};
  assign cnt_wide  = {{CW{1'b0}}, used_q};

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == nfaa_pkg::RegAddrBits);
  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nfaa_pkg::RegAddrBits) ?
                  {{(nfaa_pkg::PdataW-nfaa_pkg::CfgW){1'b0}}, cfg_q} : '0;

  assign result_valid_o    = rv_q;
  assign granted_address_o = gnt_q;
  assign status_o          = st_q;
  assign pool_empty_o      = (used_q == '0);
  assign allocated_count_o = cnt_wide[CW-1:0];

  always_comb begin
    state_d = state_q;
    cfg_d   = cfg_q;
    node_d  = node_q;
    leaf_d  = leaf_q;
    clr_d   = clr_q;
    used_d  = used_q;
    val_d   = val_q;
    kind_d  = kind_q;
    rv_d    = 1'b0;
    gnt_d   = gnt_q;
    st_d    = st_q;
    mem_ra  = node_q;
    mem_we  = 1'b0;
    mem_wa  = node_q;
    mem_wd  = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          node_d  = size_w | addr_in;
          mem_ra  = size_w | addr_in;
          kind_d  = kind_i;
          state_d = StLeaf;
        end
      end
      StClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + NodeW'(1);
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StLeaf: begin
        leaf_d = node_q;
        if (kind_q == nfaa_pkg::KindFree) begin
          if (rd_q) begin
            mem_we  = 1'b1;
            val_d   = 1'b0;
            state_d = StFix;
          end else begin
            rv_d    = 1'b1;
            gnt_d   = '0;
            st_d    = nfaa_pkg::StatusNotAlloc;
            state_d = StIdle;
          end
        end else if (!rd_q) begin
          mem_we  = 1'b1;
          mem_wd  = 1'b1;
          val_d   = 1'b1;
          state_d = StFix;
        end else begin
          state_d = StClimb;
        end
      end
      // node_q is full; look for a free right sibling on the way up.
      StClimb: begin
        if (node_q == NodeW'(1)) begin
          rv_d    = 1'b1;
          gnt_d   = '0;
          st_d    = nfaa_pkg::StatusExhausted;
          state_d = StIdle;
        end else if (!node_q[0]) begin
          node_d  = node_q | NodeW'(1);
          mem_ra  = node_q | NodeW'(1);
          state_d = StSib;
        end else begin
          node_d = node_q >> 1;
        end
      end
      StSib: begin
        state_d = rd_q ? StClimb : StDesc;
      end
      // node_q is not full; take the leftmost non-full child down to a leaf.
      StDesc: begin
        if (is_leaf) begin
          leaf_d  = node_q;
          mem_we  = 1'b1;
          mem_wd  = 1'b1;
          val_d   = 1'b1;
          state_d = StFix;
        end else begin
          node_d  = node_q << 1;
          mem_ra  = node_q << 1;
          state_d = StDchk;
        end
      end
      StDchk: begin
        if (rd_q) begin
          node_d = node_q | NodeW'(1);
        end
        state_d = StDesc;
      end
      StFix: begin
        if (node_q == NodeW'(1)) begin
          rv_d    = 1'b1;
          gnt_d   = gnt_wide[AW-1:0];
          st_d    = nfaa_pkg::StatusDone;
          used_d  = (kind_q == nfaa_pkg::KindFree) ? used_q - NodeW'(1)
                                                   : used_q + NodeW'(1);
          state_d = StIdle;
        end else begin
          mem_ra  = node_q ^ NodeW'(1);
          state_d = StFixChk;
        end
      end
      StFixChk: begin
        mem_we  = 1'b1;
        mem_wa  = node_q >> 1;
        mem_wd  = val_q & rd_q;
        val_d   = val_q & rd_q;
        node_d  = node_q >> 1;
        state_d = StFix;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A register write empties the pool and restarts the clearing pass.
    if (cfg_wr) begin
      cfg_d   = pwdata[nfaa_pkg::CfgW-1:0];
      used_d  = '0;
      clr_d   = '0;
      state_d = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cfg_q   <= nfaa_pkg::AddrBitsReset;
      clr_q   <= '0;
      used_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cfg_q   <= cfg_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    leaf_q <= leaf_d;
    val_q  <= val_d;
    kind_q <= kind_d;
    gnt_q  <= gnt_d;
    st_q   <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end
endmodule
`default_nettype wire
